// ===== rtl/pwbr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwbr_pkg
// Shared types and constants of the pulse-width byte receiver.
// ----------------------------------------------------------------------------
package pwbr_pkg;

  localparam int unsigned TickW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned BitIdxW = 3;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_TIMEOUT = 2'd2
  } pwbr_status_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_MIN   = 2'd0,
    REG_GAP_TIMEOUT = 2'd1,
    REG_ZERO_MIN    = 2'd2,
    REG_ZERO_MAX    = 2'd3
  } pwbr_reg_t;

  localparam logic [TickW-1:0] START_MIN_RST   = 16'd51;
  localparam logic [TickW-1:0] GAP_TIMEOUT_RST = 16'd10000;
  localparam logic [TickW-1:0] ZERO_MIN_RST    = 16'd21;
  localparam logic [TickW-1:0] ZERO_MAX_RST    = 16'd40;
  localparam logic [TickW-1:0] TICK_MAX        = '1;

  typedef struct packed {
    logic line_level;
  } pwbr_in_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [1:0]       frame_status;
  } pwbr_out_t;

  typedef struct packed {
    logic [TickW-1:0] start_min_ticks;
    logic [TickW-1:0] gap_timeout_ticks;
    logic [TickW-1:0] zero_min_ticks;
    logic [TickW-1:0] zero_max_ticks;
  } pwbr_cfg_t;

  typedef struct packed {
    logic      valid;
    pwbr_out_t beat;
  } pwbr_result_t;

endpackage
`default_nettype wire

// ===== rtl/pwbr_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwbr_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface pwbr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/pwbr_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwbr_decoder
// Frame state machine: times pulses and gaps, shifts in bits, flags errors.
// ----------------------------------------------------------------------------
module pwbr_decoder
  import pwbr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire logic         line_level,
  input  wire pwbr_cfg_t    cfg,
  output pwbr_result_t      result
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_GAP   = 2'd2,
    PH_PULSE = 2'd3
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [TickW-1:0]    tick_r, tick_nxt;
  logic [ByteW-1:0]    shift_r, shift_nxt;
  logic [BitIdxW-1:0]  idx_r, idx_nxt;

  logic [TickW-1:0]    tick_inc;
  logic                bit_val;
  logic [ByteW-1:0]    shift_in;
  logic                first_gap_to;

  assign tick_inc     = (tick_r == TICK_MAX) ? tick_r : tick_r + 1'b1;
  assign bit_val      = !((tick_r >= cfg.zero_min_ticks) && (tick_r <= cfg.zero_max_ticks));
  assign shift_in     = {shift_r[ByteW-2:0], bit_val};
  // a gap of one tick already meets a timeout of zero or one
  assign first_gap_to = (cfg.gap_timeout_ticks <= TickW'(1));

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    shift_nxt = shift_r;
    idx_nxt   = idx_r;
    result    = '0;
    case (phase_r)
      PH_IDLE: begin
        if (line_level) begin
          phase_nxt = PH_START;
          tick_nxt  = TickW'(1);
        end
      end
      PH_START: begin
        if (line_level) begin
          tick_nxt = tick_inc;
        end else if (tick_r < cfg.start_min_ticks) begin
          result.valid             = 1'b1;
          result.beat.frame_status = ST_SHORT;
          phase_nxt = PH_IDLE;
          tick_nxt  = '0;
        end else if (first_gap_to) begin
          result.valid             = 1'b1;
          result.beat.frame_status = ST_TIMEOUT;
          phase_nxt = PH_IDLE;
          tick_nxt  = '0;
        end else begin
          phase_nxt = PH_GAP;
          tick_nxt  = TickW'(1);
          shift_nxt = '0;
          idx_nxt   = '0;
        end
      end
      PH_GAP: begin
        if (line_level) begin
          phase_nxt = PH_PULSE;
          tick_nxt  = TickW'(1);
        end else if (tick_inc >= cfg.gap_timeout_ticks) begin
          result.valid             = 1'b1;
          result.beat.frame_status = ST_TIMEOUT;
          phase_nxt = PH_IDLE;
          tick_nxt  = '0;
          shift_nxt = '0;
          idx_nxt   = '0;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      PH_PULSE: begin
        if (line_level) begin
          tick_nxt = tick_inc;
        end else if (idx_r == '1) begin
          result.valid             = 1'b1;
          result.beat.data_byte    = shift_in;
          result.beat.frame_status = ST_OK;
          phase_nxt = PH_IDLE;
          tick_nxt  = '0;
          shift_nxt = '0;
          idx_nxt   = '0;
        end else if (first_gap_to) begin
          result.valid             = 1'b1;
          result.beat.frame_status = ST_TIMEOUT;
          phase_nxt = PH_IDLE;
          tick_nxt  = '0;
          shift_nxt = '0;
          idx_nxt   = '0;
        end else begin
          phase_nxt = PH_GAP;
          tick_nxt  = TickW'(1);
          shift_nxt = shift_in;
          idx_nxt   = idx_r + 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      shift_r <= '0;
      idx_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      shift_r <= shift_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // idle holds a clean frame context
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (tick_r == '0 && shift_r == '0 && idx_r == '0))
    else $error("idle phase with stale frame context");

  // tick counter is never zero once a pulse or gap is being timed
  a_tick_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (tick_r != '0))
    else $error("tick counter zero while timing");

  // any result ends the frame
  a_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (step && result.valid) |=> (phase_r == PH_IDLE))
    else $error("result given without returning to idle");

  // errors never carry data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (result.valid && result.beat.frame_status != ST_OK) |-> (result.beat.data_byte == '0))
    else $error("error result with nonzero byte");

endmodule
`default_nettype wire

// ===== rtl/pulse_width_byte_receiver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_width_byte_receiver
// Decodes one byte per frame from a pulse-width coded line sampled per tick.
// ----------------------------------------------------------------------------
// Feed one line sample per beat on in_ch; each sample is one timing tick.
// A frame is a high start pulse followed by eight bits, each a low gap and a
// high pulse; a pulse inside the zero window decodes as 0, any other length as
// 1, first bit in the MSB. Each frame yields exactly one result beat on out_ch:
// the byte with status ok, or a zero byte with status short-start or
// gap-timeout. The frame state machine updates in the cycle the beat is
// accepted, and the result lands in a one-deep output register, so a
// sample is accepted every cycle unless that register is full and the
// sink holds ready low. Registers written through cfg_* take effect on the
// next sample; write them only while the line is idle.
// ----------------------------------------------------------------------------
module pulse_width_byte_receiver
  import pwbr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  pwbr_stream_if.sink             in_ch,
  pwbr_stream_if.source           out_ch,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [TickW-1:0]   cfg_data
);

  pwbr_cfg_t    cfg_r;
  pwbr_result_t result;
  logic         out_valid_r;
  pwbr_out_t    out_beat_r;
  logic         step;

  // accept a sample whenever the result register is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign step        = in_ch.valid && in_ch.ready;

  // hold the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_min_ticks   <= START_MIN_RST;
      cfg_r.gap_timeout_ticks <= GAP_TIMEOUT_RST;
      cfg_r.zero_min_ticks    <= ZERO_MIN_RST;
      cfg_r.zero_max_ticks    <= ZERO_MAX_RST;
    end else if (cfg_we) begin
      case (pwbr_reg_t'(cfg_index))
        REG_START_MIN:   cfg_r.start_min_ticks   <= cfg_data;
        REG_GAP_TIMEOUT: cfg_r.gap_timeout_ticks <= cfg_data;
        REG_ZERO_MIN:    cfg_r.zero_min_ticks    <= cfg_data;
        REG_ZERO_MAX:    cfg_r.zero_max_ticks    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pwbr_decoder u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .line_level (in_ch.payload.line_level),
    .cfg        (cfg_r),
    .result     (result)
  );

  // load a fresh result beat, or drop the old one once the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && result.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.valid) begin
      out_beat_r <= result.beat;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_beat_r;

  // a pending result is never overwritten before it is taken
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !step)
    else $error("sample accepted while result beat is stalled");

  // a new result beat appears only after an accepted sample
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step))
    else $error("result beat without accepted sample");

  // status codes stay in range
  a_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_beat_r.frame_status == ST_OK ||
                     out_beat_r.frame_status == ST_SHORT ||
                     out_beat_r.frame_status == ST_TIMEOUT))
    else $error("result beat with undefined status");

endmodule
`default_nettype wire

// ===== tb/tb_pulse_width_byte_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulse_width_byte_receiver
// Self-checking bench for the pulse-width byte receiver. Line samples are
// streamed one per beat. A software copy of the frame decoder predicts every
// status and byte beat, and each result beat is checked against it in order.
// Directed frames hit the register extremes and the edges of the zero window.
// Random phases then mix well-formed frames, broken frames and line noise
// under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_pulse_width_byte_receiver;
  import pwbr_pkg::*;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;

  typedef enum logic [1:0] {
    LINE_IDLE  = 2'd0,
    LINE_START = 2'd1,
    LINE_GAP   = 2'd2,
    LINE_PULSE = 2'd3
  } line_phase_t;

  // Software frame decoder: tracks the line state, predicts frame results
  // and matches them against the result beats.
  class byte_frame_tracker;
    pwbr_cfg_t        cfg;
    line_phase_t      phase;
    logic [TickW-1:0] ticks;
    logic [ByteW-1:0] shift;
    logic [3:0]       nbits;
    pwbr_out_t        frames_due[$];
    int               samples_seen;
    int               frames_made;
    int               mismatches;

    function new();
      cfg.start_min_ticks   = START_MIN_RST;
      cfg.gap_timeout_ticks = GAP_TIMEOUT_RST;
      cfg.zero_min_ticks    = ZERO_MIN_RST;
      cfg.zero_max_ticks    = ZERO_MAX_RST;
      phase        = LINE_IDLE;
      ticks        = '0;
      shift        = '0;
      nbits        = '0;
      samples_seen = 0;
      frames_made  = 0;
      mismatches   = 0;
    endfunction

    function void write_reg(pwbr_reg_t idx, logic [TickW-1:0] val);
      case (idx)
        REG_START_MIN:   cfg.start_min_ticks   = val;
        REG_GAP_TIMEOUT: cfg.gap_timeout_ticks = val;
        REG_ZERO_MIN:    cfg.zero_min_ticks    = val;
        REG_ZERO_MAX:    cfg.zero_max_ticks    = val;
        default: ;
      endcase
    endfunction

    function void close_frame(logic [ByteW-1:0] data, pwbr_status_t status);
      pwbr_out_t res;
      res.data_byte    = data;
      res.frame_status = status;
      frames_due.push_back(res);
      frames_made++;
      phase = LINE_IDLE;
      ticks = '0;
      shift = '0;
      nbits = '0;
    endfunction

    function void bump();
      if (ticks != TICK_MAX) ticks = ticks + 1'b1;
    endfunction

    // The sample that enters a gap is already its first tick.
    function void open_gap();
      phase = LINE_GAP;
      ticks = TickW'(1);
      if (ticks >= cfg.gap_timeout_ticks) close_frame('0, ST_TIMEOUT);
    endfunction

    function void feed_sample(logic lvl);
      logic bitv;
      samples_seen++;
      case (phase)
        LINE_IDLE: begin
          if (lvl) begin
            phase = LINE_START;
            ticks = TickW'(1);
          end
        end
        LINE_START: begin
          if (lvl) begin
            bump();
          end else if (ticks < cfg.start_min_ticks) begin
            close_frame('0, ST_SHORT);
          end else begin
            shift = '0;
            nbits = '0;
            open_gap();
          end
        end
        LINE_GAP: begin
          if (lvl) begin
            phase = LINE_PULSE;
            ticks = TickW'(1);
          end else begin
            bump();
            if (ticks >= cfg.gap_timeout_ticks) close_frame('0, ST_TIMEOUT);
          end
        end
        default: begin
          if (lvl) begin
            bump();
          end else begin
            bitv  = (ticks >= cfg.zero_min_ticks && ticks <= cfg.zero_max_ticks) ? 1'b0 : 1'b1;
            shift = {shift[ByteW-2:0], bitv};
            nbits = nbits + 1'b1;
            if (nbits >= 4'd8) close_frame(shift, ST_OK);
            else open_gap();
          end
        end
      endcase
    endfunction

    function void match_frame(pwbr_out_t got);
      pwbr_out_t want;
      if (frames_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result beat: byte %02h status %0d",
                   got.data_byte, got.frame_status);
        mismatches++;
      end else begin
        want = frames_due.pop_front();
        if (got.data_byte !== want.data_byte || got.frame_status !== want.frame_status) begin
          if (mismatches < 10)
            $display("result mismatch: expected byte %02h status %0d, got byte %02h status %0d",
                     want.data_byte, want.frame_status, got.data_byte, got.frame_status);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [TickW-1:0]   cfg_data;

  pwbr_stream_if #(.payload_t(pwbr_in_t))  in_ch ();
  pwbr_stream_if #(.payload_t(pwbr_out_t)) out_ch ();

  pulse_width_byte_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  byte_frame_tracker tracker = new();

  bit hold_req;     // ask the result sink for one long hold-off
  bit sender_calm;  // suppress sender gaps for the current burst
  int cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bound the run; a hang anywhere ends here.
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Result sink: check each accepted beat at the rising edge, then pick the
  // next ready level at the falling edge. Alternate calm stretches (always
  // ready) with stretches of short and occasional long stalls.
  initial begin : result_sink
    int stall_left;
    int calm_left;
    bit calm;
    stall_left   = 0;
    calm_left    = 0;
    calm         = 1'b1;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) tracker.match_frame(out_ch.payload);
      @(negedge clk);
      if (hold_req) begin
        // long hold-off: the output register fills and the input stalls
        stall_left = HOLD_CYCLES;
        hold_req   = 1'b0;
      end
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 2) == 0);
        calm_left = $urandom_range(20, 200);
      end else begin
        calm_left--;
      end
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        out_ch.ready = 1'b0;
        stall_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Offer one line sample, with an optional random gap first, and hold it
  // until the block takes the beat.
  task automatic send_sample(logic lvl, bit may_idle);
    int wait_n;
    @(negedge clk);
    if (may_idle && !sender_calm && $urandom_range(0, 99) < 30) begin
      wait_n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      in_ch.valid = 1'b0;
      repeat (wait_n) @(negedge clk);
    end
    in_ch.valid              = 1'b1;
    in_ch.payload.line_level = lvl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.feed_sample(lvl);
  endtask

  // Hold the line at one level for n ticks; long runs go back to back.
  task automatic send_level(logic lvl, int n);
    bit may_idle;
    may_idle = (n <= 64);
    repeat (n) send_sample(lvl, may_idle);
  endtask

  // Start pulse, eight gap/pulse pairs, and the falling sample that ends
  // the last bit.
  task automatic send_frame(int start_len, input int gaps [8], input int pulses [8]);
    send_level(1'b1, start_len);
    for (int i = 0; i < 8; i++) begin
      send_level(1'b0, gaps[i]);
      send_level(1'b1, pulses[i]);
    end
    send_level(1'b0, 1);
  endtask

  // Drive the decoder back to idle by the shortest path: drop a start or a
  // pulse, raise a gap.
  task automatic bring_line_idle();
    while (tracker.phase != LINE_IDLE) send_sample(tracker.phase == LINE_GAP, 1'b0);
  endtask

  // Finish the frame in flight, stop offering beats, wait for every result
  // beat and let the pipeline settle.
  task automatic drain_results();
    bring_line_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (tracker.frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(pwbr_reg_t idx, logic [TickW-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  task automatic set_config(logic [TickW-1:0] sm, logic [TickW-1:0] to,
                            logic [TickW-1:0] zmin, logic [TickW-1:0] zmax);
    drain_results();
    write_reg(REG_START_MIN, sm);
    write_reg(REG_GAP_TIMEOUT, to);
    write_reg(REG_ZERO_MIN, zmin);
    write_reg(REG_ZERO_MAX, zmax);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One random burst under a small configuration: mostly a frame with
  // lengths drawn around every threshold, sometimes plain line noise.
  task automatic random_burst();
    int sm;
    int to;
    int wmax;
    int n_start;
    int n_gap;
    sm          = int'(tracker.cfg.start_min_ticks);
    to          = int'(tracker.cfg.gap_timeout_ticks);
    wmax        = (tracker.cfg.zero_max_ticks > tracker.cfg.zero_min_ticks) ?
                  int'(tracker.cfg.zero_max_ticks) : int'(tracker.cfg.zero_min_ticks);
    sender_calm = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(3, 12))
        send_level(1'($urandom_range(0, 1)), $urandom_range(1, 6));
      bring_line_idle();
    end else begin
      send_level(1'b0, $urandom_range(0, 3));
      if (sm > 1 && $urandom_range(0, 4) == 0) n_start = $urandom_range(1, sm - 1);
      else n_start = $urandom_range(sm, sm + 3);
      send_level(1'b1, n_start);
      for (int i = 0; i < 8 && tracker.phase != LINE_IDLE; i++) begin
        // mostly stay under the timeout, now and then run right into it
        if (to <= 1 || $urandom_range(0, 19) == 0) n_gap = to;
        else n_gap = $urandom_range(1, to - 1);
        send_level(1'b0, n_gap);
        if (tracker.phase != LINE_IDLE) send_level(1'b1, $urandom_range(1, wmax + 3));
      end
      if (tracker.phase != LINE_IDLE) send_level(1'b0, 1);
    end
  endtask

  initial begin : stimulus
    int base_samples;
    int base_frames;
    int sm;
    int to;
    int zmin;
    int zmax;
    rst_n                    = 1'b0;
    cfg_we                   = 1'b0;
    cfg_index                = REG_START_MIN;
    cfg_data                 = '0;
    in_ch.valid              = 1'b0;
    in_ch.payload.line_level = 1'b0;
    hold_req                 = 1'b0;
    sender_calm              = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset registers: start exactly at the minimum, pulses on both edges of
    // the zero window and just outside it.
    send_level(1'b0, 3);
    send_frame(51, '{1, 2, 1, 3, 1, 9, 1, 1}, '{21, 40, 20, 41, 30, 1, 50, 21});
    send_level(1'b0, 2);
    // start one tick short, then a single-tick start
    send_level(1'b1, 50);
    send_level(1'b0, 2);
    send_level(1'b1, 1);
    send_level(1'b0, 1);

    // Timeout of one: the first gap tick aborts.
    set_config(16'd1, 16'd1, 16'd1, 16'd1);
    send_level(1'b1, 1);
    send_level(1'b0, 2);

    // Timeout of two: alternating zero and one bits, then a timeout.
    set_config(16'd1, 16'd2, 16'd1, 16'd1);
    send_frame(1, '{1, 1, 1, 1, 1, 1, 1, 1}, '{1, 2, 1, 2, 1, 2, 1, 2});
    send_level(1'b1, 3);
    send_level(1'b0, 2);

    // Top of range: any short start is rejected.
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
    send_level(1'b1, 3);
    send_level(1'b0, 1);

    // Empty zero window: every pulse is a one.
    set_config(16'd1, 16'hFFFF, 16'hFFFF, 16'd1);
    send_frame(2, '{1, 1, 2, 1, 3, 1, 1, 1}, '{1, 2, 3, 4, 5, 6, 7, 8});

    // Full zero window: every pulse is a zero, a long pulse included.
    set_config(16'd2, 16'hFFFF, 16'd1, 16'hFFFF);
    send_level(1'b1, 1);
    send_level(1'b0, 1);
    send_frame(2, '{1, 1, 1, 1, 1, 1, 1, 1}, '{70, 1, 2, 3, 1, 1, 1, 1});

    // Random phases, each under its own small configuration.
    for (int p = 0; p < 4; p++) begin
      sm   = $urandom_range(1, 5);
      to   = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
      zmin = $urandom_range(1, 4);
      zmax = $urandom_range((zmin > 1) ? zmin - 1 : 1, zmin + 4);
      set_config(TickW'(sm), TickW'(to), TickW'(zmin), TickW'(zmax));
      if (p == 1) hold_req = 1'b1;
      base_samples = tracker.samples_seen;
      base_frames  = tracker.frames_made;
      while (tracker.samples_seen - base_samples < 120 ||
             tracker.frames_made - base_frames < 3)
        random_burst();
    end

    drain_results();
    if (tracker.mismatches == 0 && tracker.frames_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
